// ===== hdl/ftte_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftte_pkg
// Shared types and constants of the frame table trigger extractor.
// ----------------------------------------------------------------------------
package ftte_pkg;

    localparam int MAX_FRAMES_DEF = 256;

    localparam int WORD_W  = 32;
    localparam int PW_W    = 25;
    localparam int FRAME_W = 9;
    localparam int OFS_W   = 27;
    localparam int TIDX_W  = 8;
    localparam int AREA_W  = 29;

    localparam logic [WORD_W-1:0] MAGIC_NATIVE  = 32'hCAFEBABE;
    localparam logic [WORD_W-1:0] MAGIC_SWAPPED = 32'hBEBAFECA;
    localparam logic [PW_W-1:0]   SIZE_LIMIT    = 25'd16777216;
    localparam logic [PW_W-1:0]   POS_MAX       = {PW_W{1'b1}};
    localparam logic [3:0]        HDR_START     = 4'hB;

    localparam logic [2:0] ST_FOUND     = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
    localparam logic [2:0] ST_TOO_SMALL = 3'd2;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd3;
    localparam logic [2:0] ST_BAD_COUNT = 3'd4;
    localparam logic [2:0] ST_BAD_LEN   = 3'd5;
    localparam logic [2:0] ST_OVERRUN   = 3'd6;
    localparam logic [2:0] ST_NONE      = 3'd7;

    typedef enum logic [1:0] {
        KIND_MAGIC = 2'd0,
        KIND_COUNT = 2'd1,
        KIND_TABLE = 2'd2,
        KIND_DATA  = 2'd3
    } word_kind_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [PW_W-1:0]   pw;
        logic              last;
        word_kind_t        kind;
        logic [TIDX_W-1:0] tbl_idx;
        logic [PW_W-1:0]   data_idx;
    } req_t;

endpackage
`default_nettype wire

// ===== hdl/ftte_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftte_front
// Accepts packet words and tags each with its place in the packet.
// ----------------------------------------------------------------------------
module ftte_front #(
    parameter int MAX_FRAMES = ftte_pkg::MAX_FRAMES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output      logic                        in_ready,
    input  wire logic [ftte_pkg::WORD_W-1:0] word_value,
    input  wire logic [ftte_pkg::PW_W-1:0]   packet_words,
    input  wire logic                        last_word,
    input  wire logic                        q_full,
    output      logic                        q_push,
    output      ftte_pkg::req_t              q_req
);

    logic [ftte_pkg::PW_W-1:0]    pos_reg, pos_next;
    logic [ftte_pkg::FRAME_W-1:0] total_reg, total_next;
    logic [ftte_pkg::PW_W:0]      tbl_end;
    logic [ftte_pkg::PW_W-1:0]    pos_m2;

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;
    assign tbl_end  = (ftte_pkg::PW_W+1)'(total_reg) + (ftte_pkg::PW_W+1)'(2);
    assign pos_m2   = pos_reg - ftte_pkg::PW_W'(2);

    always_comb
    begin
        q_req.word     = word_value;
        q_req.pw       = packet_words;
        q_req.last     = last_word;
        q_req.tbl_idx  = pos_m2[ftte_pkg::TIDX_W-1:0];
        q_req.data_idx = pos_m2 - ftte_pkg::PW_W'(total_reg);
        if (pos_reg == '0)
            q_req.kind = ftte_pkg::KIND_MAGIC;
        else if (pos_reg == ftte_pkg::PW_W'(1))
            q_req.kind = ftte_pkg::KIND_COUNT;
        else if ({1'b0, pos_reg} < tbl_end)
            q_req.kind = ftte_pkg::KIND_TABLE;
        else
            q_req.kind = ftte_pkg::KIND_DATA;
    end

    always_comb
    begin
        pos_next   = pos_reg;
        total_next = total_reg;
        if (q_push)
        begin
            if (last_word)
            begin
                pos_next   = '0;
                total_next = '0;
            end
            else
            begin
                if (pos_reg != ftte_pkg::POS_MAX)
                    pos_next = pos_reg + ftte_pkg::PW_W'(1);
                if (pos_reg == ftte_pkg::PW_W'(1)
                    && word_value <= ftte_pkg::WORD_W'(MAX_FRAMES))
                    total_next = word_value[ftte_pkg::FRAME_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            total_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            total_reg <= total_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/ftte_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftte_queue
// Four-entry request queue between the front and back parts.
// ----------------------------------------------------------------------------
module ftte_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire ftte_pkg::req_t push_req,
    output      logic           full,
    input  wire logic           pop,
    output      logic           head_valid,
    output      ftte_pkg::req_t head_req
);

    ftte_pkg::req_t entry_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full       = (count_reg == 3'd4);
    assign head_valid = (count_reg != 3'd0);
    assign head_req   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        count_next  = count_reg + 3'(do_push) - 3'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/ftte_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftte_back
// Checks the packet, holds the frame length table and walks the frames.
// ----------------------------------------------------------------------------
module ftte_back #(
    parameter int MAX_FRAMES = ftte_pkg::MAX_FRAMES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        head_valid,
    input  wire ftte_pkg::req_t              head_req,
    output      logic                        pop,
    output      logic                        out_valid,
    input  wire logic                        out_ready,
    output      logic [2:0]                  status,
    output      logic [ftte_pkg::WORD_W-1:0] trigger_number,
    output      logic [ftte_pkg::WORD_W-1:0] tag_word
);

    localparam int ADDR_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    typedef enum logic [1:0] {
        S_RUN = 2'b01,
        S_FIN = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [ftte_pkg::WORD_W-1:0] mem [MAX_FRAMES];
    logic [ftte_pkg::WORD_W-1:0] rd_reg;
    logic                        rd_ok_reg;
    logic                        wr_en;
    logic [ADDR_W-1:0]           wr_addr;

    logic [ftte_pkg::FRAME_W-1:0] total_reg, total_next;
    logic [ftte_pkg::FRAME_W-1:0] cursor_reg, cursor_next;
    logic [ftte_pkg::OFS_W-1:0]   offset_reg, offset_next;
    logic signed [ftte_pkg::AREA_W-1:0] area_reg, area_next;
    logic [2:0]  verdict_reg, verdict_next;
    logic        decided_reg, decided_next;
    logic        start_reg, start_next;
    logic        walk_reg, walk_next;
    logic [ftte_pkg::WORD_W-1:0] trig_reg, trig_next;
    logic [ftte_pkg::WORD_W-1:0] tag_reg, tag_next;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  status_reg, status_next;
    logic [ftte_pkg::WORD_W-1:0] otrig_reg, otrig_next;
    logic [ftte_pkg::WORD_W-1:0] otag_reg, otag_next;

    logic        walk_clear;
    logic signed [33:0] lo_s, end_s, area_s;
    logic [ftte_pkg::OFS_W+1:0] round_sum;
    logic [ftte_pkg::PW_W:0]    d_ext, s_ext;
    logic signed [ftte_pkg::AREA_W-1:0] area_of_word;
    logic [2:0]  final_status;

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign trigger_number = otrig_reg;
    assign tag_word       = otag_reg;

    assign walk_clear = !walk_reg || decided_reg;
    assign pop        = (state_reg == S_RUN) && head_valid && walk_clear;

    assign lo_s      = 34'(signed'(rd_reg));
    assign end_s     = 34'(signed'({1'b0, offset_reg})) + lo_s;
    assign area_s    = 34'(area_reg);
    assign round_sum = end_s[ftte_pkg::OFS_W+1:0] + (ftte_pkg::OFS_W+2)'(3);
    assign d_ext     = {1'b0, head_req.data_idx};
    assign s_ext     = {1'b0, offset_reg[ftte_pkg::OFS_W-1:2]};
    assign area_of_word = signed'(
        {2'b00, head_req.pw, 2'b00}
        - {ftte_pkg::FRAME_W'(0), total_reg, 2'b00} - ftte_pkg::AREA_W'(8));
    assign final_status = decided_reg ? verdict_reg : ftte_pkg::ST_NONE;

    assign wr_en   = pop && !decided_reg && (head_req.kind == ftte_pkg::KIND_TABLE);
    assign wr_addr = head_req.tbl_idx[ADDR_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        cursor_next    = cursor_reg;
        offset_next    = offset_reg;
        area_next      = area_reg;
        verdict_next   = verdict_reg;
        decided_next   = decided_reg;
        start_next     = start_reg;
        walk_next      = walk_reg;
        trig_next      = trig_reg;
        tag_next       = tag_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        otrig_next     = otrig_reg;
        otag_next      = otag_reg;

        // one frame of the walk per cycle while the table read is not held by a write
        if (walk_reg && !decided_reg && rd_ok_reg)
        begin
            if (cursor_reg >= total_reg)
            begin
                verdict_next = ftte_pkg::ST_NONE;
                decided_next = 1'b1;
            end
            else if (lo_s <= 34'sd0)
            begin
                verdict_next = ftte_pkg::ST_BAD_LEN;
                decided_next = 1'b1;
            end
            else if (end_s > area_s)
            begin
                verdict_next = ftte_pkg::ST_OVERRUN;
                decided_next = 1'b1;
            end
            else if (rd_reg[1:0] != 2'b00)
            begin
                offset_next = {round_sum[ftte_pkg::OFS_W-1:2], 2'b00};
                cursor_next = cursor_reg + ftte_pkg::FRAME_W'(1);
            end
            else
                walk_next = 1'b0;
        end

        if (pop)
        begin
            if (!decided_reg)
            begin
                unique case (head_req.kind)
                    ftte_pkg::KIND_MAGIC:
                    begin
                        if (head_req.pw == '0 || head_req.pw > ftte_pkg::SIZE_LIMIT)
                        begin
                            verdict_next = ftte_pkg::ST_BAD_SIZE;
                            decided_next = 1'b1;
                        end
                        else if (head_req.pw < ftte_pkg::PW_W'(2))
                        begin
                            verdict_next = ftte_pkg::ST_TOO_SMALL;
                            decided_next = 1'b1;
                        end
                        else if (head_req.word != ftte_pkg::MAGIC_NATIVE
                                 && head_req.word != ftte_pkg::MAGIC_SWAPPED)
                        begin
                            verdict_next = ftte_pkg::ST_BAD_MAGIC;
                            decided_next = 1'b1;
                        end
                    end
                    ftte_pkg::KIND_COUNT:
                    begin
                        if (head_req.word > ftte_pkg::WORD_W'(MAX_FRAMES))
                        begin
                            verdict_next = ftte_pkg::ST_BAD_COUNT;
                            decided_next = 1'b1;
                        end
                        else
                        begin
                            total_next  = head_req.word[ftte_pkg::FRAME_W-1:0];
                            cursor_next = '0;
                            offset_next = '0;
                            if (head_req.word == '0)
                            begin
                                verdict_next = ftte_pkg::ST_NONE;
                                decided_next = 1'b1;
                            end
                        end
                    end
                    ftte_pkg::KIND_TABLE:
                    begin
                        if ({1'b0, head_req.tbl_idx} + ftte_pkg::FRAME_W'(1) == total_reg)
                        begin
                            walk_next = 1'b1;
                            area_next = area_of_word;
                        end
                    end
                    ftte_pkg::KIND_DATA:
                    begin
                        if (!start_reg)
                        begin
                            if (d_ext == s_ext)
                            begin
                                if (head_req.word[30:27] == ftte_pkg::HDR_START)
                                begin
                                    start_next = 1'b1;
                                    trig_next  = {16'h0000, head_req.word[15:0]};
                                end
                                else
                                begin
                                    offset_next = offset_reg + rd_reg[ftte_pkg::OFS_W-1:0];
                                    cursor_next = cursor_reg + ftte_pkg::FRAME_W'(1);
                                    walk_next   = 1'b1;
                                    area_next   = area_of_word;
                                end
                            end
                        end
                        else if (d_ext == s_ext + (ftte_pkg::PW_W+1)'(1))
                            trig_next = {head_req.word[31:16], trig_reg[15:0]};
                        else if (d_ext == s_ext + (ftte_pkg::PW_W+1)'(3))
                        begin
                            tag_next     = head_req.word;
                            verdict_next = ftte_pkg::ST_FOUND;
                            decided_next = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (head_req.last)
                state_next = S_FIN;
        end

        unique case (state_reg)
            S_RUN:
            begin
            end
            S_FIN:
            begin
                if (walk_clear && (!out_valid_reg || out_ready))
                begin
                    out_valid_next = 1'b1;
                    status_next    = final_status;
                    otrig_next     = (final_status == ftte_pkg::ST_FOUND) ? trig_reg : '0;
                    otag_next      = (final_status == ftte_pkg::ST_FOUND) ? tag_reg : '0;
                    state_next     = S_RUN;
                    total_next     = '0;
                    cursor_next    = '0;
                    offset_next    = '0;
                    verdict_next   = ftte_pkg::ST_NONE;
                    decided_next   = 1'b0;
                    start_next     = 1'b0;
                    walk_next      = 1'b0;
                    trig_next      = '0;
                    tag_next       = '0;
                end
            end
            default:
                state_next = S_RUN;
        endcase
    end

    // length table, read port follows the cursor
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= head_req.word;
        rd_reg <= mem[cursor_next[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            rd_ok_reg     <= 1'b0;
            total_reg     <= '0;
            cursor_reg    <= '0;
            offset_reg    <= '0;
            area_reg      <= '0;
            verdict_reg   <= ftte_pkg::ST_NONE;
            decided_reg   <= 1'b0;
            start_reg     <= 1'b0;
            walk_reg      <= 1'b0;
            trig_reg      <= '0;
            tag_reg       <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ftte_pkg::ST_NONE;
            otrig_reg     <= '0;
            otag_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_ok_reg     <= !(wr_en && wr_addr == cursor_next[ADDR_W-1:0]);
            total_reg     <= total_next;
            cursor_reg    <= cursor_next;
            offset_reg    <= offset_next;
            area_reg      <= area_next;
            verdict_reg   <= verdict_next;
            decided_reg   <= decided_next;
            start_reg     <= start_next;
            walk_reg      <= walk_next;
            trig_reg      <= trig_next;
            tag_reg       <= tag_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            otrig_reg     <= otrig_next;
            otag_reg      <= otag_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/frame_table_trigger_extractor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// result: registered after the last word leaves the queue and any walk ends
// throughput: one word per cycle at the input unless the queue is full; the back
//   end pauses on each packet's result, during each frame walk, and while a walk
//   waits on a table entry just written; the queue absorbs these
// reset: asynchronous, clears all control state; the length table is not cleared
// ----------------------------------------------------------------------------
// frame_table_trigger_extractor
// Extracts trigger number and tag from a packet with a frame length table.
// ----------------------------------------------------------------------------
module frame_table_trigger_extractor #(
    parameter int MAX_FRAMES = ftte_pkg::MAX_FRAMES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output      logic                        in_ready,
    input  wire logic [ftte_pkg::WORD_W-1:0] word_value,
    input  wire logic [ftte_pkg::PW_W-1:0]   packet_words,
    input  wire logic                        last_word,
    output      logic                        out_valid,
    input  wire logic                        out_ready,
    output      logic [2:0]                  status,
    output      logic [ftte_pkg::WORD_W-1:0] trigger_number,
    output      logic [ftte_pkg::WORD_W-1:0] tag_word
);

    logic           q_full, q_push, q_pop, q_head_valid;
    ftte_pkg::req_t q_req, q_head;

    ftte_front #(.MAX_FRAMES(MAX_FRAMES)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .word_value   (word_value),
        .packet_words (packet_words),
        .last_word    (last_word),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_req        (q_req)
    );

    ftte_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_req   (q_req),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_req   (q_head)
    );

    ftte_back #(.MAX_FRAMES(MAX_FRAMES)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (q_head_valid),
        .head_req       (q_head),
        .pop            (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .trigger_number (trigger_number),
        .tag_word       (tag_word)
    );

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds directed and random packets into the trigger extractor, predicts the
// status, trigger number and tag per packet, and compares with the outputs.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct packed {
        logic [2:0]  st;
        logic [31:0] trig;
        logic [31:0] tag;
    } verdict_t;

    typedef struct {
        logic [31:0] w;
        logic [24:0] pw;
        logic        last;
        logic        has_exp;
        verdict_t    exp;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] word_value;
    logic [24:0] packet_words;
    logic        last_word;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [31:0] trigger_number;
    logic [31:0] tag_word;

    frame_table_trigger_extractor u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .word_value     (word_value),
        .packet_words   (packet_words),
        .last_word      (last_word),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .trigger_number (trigger_number),
        .tag_word       (tag_word)
    );

    // predictor state
    logic [24:0] pos_q;
    logic [8:0]  nframes_q;
    logic [31:0] len_tbl [256];
    logic [8:0]  cursor_q;
    logic [31:0] offset_q;
    logic [2:0]  code_q;
    logic        done_q;
    logic [31:0] trig_q;
    logic [31:0] tag_q;
    logic        hdr_seen_q;

    verdict_t    expected_q[$];
    stim_row_t   rows[$];
    int          errors;
    int          mismatches;
    int          idle_cycles;
    logic        hold_off;
    logic        stim_done;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void clear_state();
        pos_q      = '0;
        nframes_q  = '0;
        cursor_q   = '0;
        offset_q   = '0;
        code_q     = ftte_pkg::ST_NONE;
        done_q     = 1'b0;
        trig_q     = '0;
        tag_q      = '0;
        hdr_seen_q = 1'b0;
    endfunction

    function automatic void decide(logic [2:0] c);
        code_q = c;
        done_q = 1'b1;
    endfunction

    function automatic longint signed frame_len(logic [8:0] idx);
        return longint'($signed(len_tbl[idx[7:0]]));
    endfunction

    function automatic void walk_frames(logic [24:0] pw);
        longint signed area;
        longint signed lo;
        longint signed at;
        area = 4 * (longint'(pw) - 2 - longint'(nframes_q));
        while (cursor_q < nframes_q) begin
            lo = frame_len(cursor_q);
            at = longint'(offset_q);
            if (lo <= 0) begin
                decide(ftte_pkg::ST_BAD_LEN);
                return;
            end
            if (at + lo > area) begin
                decide(ftte_pkg::ST_OVERRUN);
                return;
            end
            if (lo[1:0] != 2'b00) begin
                offset_q = 32'((at + lo + 3) & ~longint'(3));
                cursor_q = cursor_q + 9'd1;
            end
            else
                return;
        end
        decide(ftte_pkg::ST_NONE);
    endfunction

    // returns 1 when the word completes a packet
    function automatic bit predict_word(logic [31:0] w, logic [24:0] pw, logic last,
                                        output verdict_t v);
        logic [31:0] d;
        logic [31:0] s;
        if (!done_q) begin
            if (pos_q == 0) begin
                if (pw == 0 || pw > ftte_pkg::SIZE_LIMIT) decide(ftte_pkg::ST_BAD_SIZE);
                else if (pw < 2) decide(ftte_pkg::ST_TOO_SMALL);
                else if (w != ftte_pkg::MAGIC_NATIVE && w != ftte_pkg::MAGIC_SWAPPED)
                    decide(ftte_pkg::ST_BAD_MAGIC);
            end
            else if (pos_q == 1) begin
                if (w > 32'd256) decide(ftte_pkg::ST_BAD_COUNT);
                else begin
                    nframes_q = w[8:0];
                    cursor_q  = '0;
                    offset_q  = '0;
                    if (nframes_q == 0) walk_frames(pw);
                end
            end
            else if (32'(pos_q) < 2 + 32'(nframes_q)) begin
                len_tbl[8'(pos_q - 2)] = w;
                if (32'(pos_q) == 1 + 32'(nframes_q)) walk_frames(pw);
            end
            else begin
                d = 32'(pos_q) - 2 - 32'(nframes_q);
                s = offset_q >> 2;
                if (!hdr_seen_q) begin
                    if (d == s) begin
                        if (w[30:27] == ftte_pkg::HDR_START) begin
                            hdr_seen_q = 1'b1;
                            trig_q     = {16'h0, w[15:0]};
                        end
                        else begin
                            offset_q = offset_q + len_tbl[cursor_q[7:0]];
                            cursor_q = cursor_q + 9'd1;
                            walk_frames(pw);
                        end
                    end
                end
                else if (d == s + 1)
                    trig_q = trig_q | {w[31:16], 16'h0};
                else if (d == s + 3) begin
                    tag_q = w;
                    decide(ftte_pkg::ST_FOUND);
                end
            end
        end
        if (pos_q != ftte_pkg::POS_MAX) pos_q = pos_q + 25'd1;
        v = '0;
        if (!last) return 1'b0;
        v.st   = done_q ? code_q : ftte_pkg::ST_NONE;
        v.trig = (v.st == ftte_pkg::ST_FOUND) ? trig_q : '0;
        v.tag  = (v.st == ftte_pkg::ST_FOUND) ? tag_q : '0;
        clear_state();
        return 1'b1;
    endfunction

    function automatic void add_row(logic [31:0] w, logic [24:0] pw, logic last);
        stim_row_t r;
        r.w       = w;
        r.pw      = pw;
        r.last    = last;
        r.has_exp = 1'b0;
        r.exp     = '0;
        rows.push_back(r);
    endfunction

    function automatic void add_checked(logic [31:0] w, logic [24:0] pw, logic [2:0] st);
        stim_row_t r;
        r.w       = w;
        r.pw      = pw;
        r.last    = 1'b1;
        r.has_exp = 1'b1;
        r.exp     = '{st, 32'h0, 32'h0};
        rows.push_back(r);
    endfunction

    // builds a packet with random frames, some unaligned, bad or cut short
    function automatic void build_packet(bit noisy);
        int nf;
        int lens[$];
        int data_words;
        int k;
        int j;
        int total;
        int start_at;
        int pick;
        logic [31:0] w;
        nf = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 5);
        if ($urandom_range(0, 40) == 0 && rows.size() < 380) nf = $urandom_range(250, 256);
        data_words = 0;
        for (k = 0; k < nf; k++) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) lens.push_back(4 * $urandom_range(4, 7));
            else if (pick < 9) lens.push_back($urandom_range(1, 11));
            else lens.push_back(noisy ? -$urandom_range(0, 3) : 8);
            if (lens[k] > 0) data_words += (lens[k] + 3) / 4;
        end
        if (nf > 100) data_words = 0;
        total = 2 + nf + data_words;
        if (noisy && $urandom_range(0, 2) == 0) total = total - $urandom_range(0, 6);
        if (total < 2) total = 2;
        add_row($urandom_range(0, 1) ? ftte_pkg::MAGIC_NATIVE : ftte_pkg::MAGIC_SWAPPED,
                25'(total), 1'b0);
        add_row(32'(nf), 25'(total), total == 2);
        for (k = 0; k < nf && 2 + k < total; k++)
            add_row(32'(lens[k]), 25'(total), 2 + k == total - 1);
        start_at = 2 + nf;
        for (j = start_at; j < total; j++) begin
            w = $urandom;
            if ($urandom_range(0, 2) != 0) w[30:27] = ftte_pkg::HDR_START;
            add_row(w, 25'(total), j == total - 1);
        end
    endfunction

    function automatic void build_directed();
        add_checked(ftte_pkg::MAGIC_NATIVE, 25'd0, ftte_pkg::ST_BAD_SIZE);
        add_checked(ftte_pkg::MAGIC_NATIVE, 25'd16777217, ftte_pkg::ST_BAD_SIZE);
        add_checked(ftte_pkg::MAGIC_NATIVE, 25'h1FFFFFF, ftte_pkg::ST_BAD_SIZE);
        add_checked(ftte_pkg::MAGIC_NATIVE, 25'd1, ftte_pkg::ST_TOO_SMALL);
        add_checked(32'h0, 25'd4, ftte_pkg::ST_BAD_MAGIC);
        add_checked(32'hFFFFFFFF, 25'd16777216, ftte_pkg::ST_BAD_MAGIC);
        add_row(ftte_pkg::MAGIC_SWAPPED, 25'd2, 1'b0);
        add_checked(32'd257, 25'd2, ftte_pkg::ST_BAD_COUNT);
        add_row(ftte_pkg::MAGIC_NATIVE, 25'd3, 1'b0);
        add_checked(32'hFFFFFFFF, 25'd3, ftte_pkg::ST_BAD_COUNT);
        add_row(ftte_pkg::MAGIC_NATIVE, 25'd2, 1'b0);
        add_checked(32'd0, 25'd2, ftte_pkg::ST_NONE);
        add_row(ftte_pkg::MAGIC_NATIVE, 25'd3, 1'b0);
        add_row(32'd1, 25'd3, 1'b0);
        add_checked(32'h80000000, 25'd3, ftte_pkg::ST_BAD_LEN);
        add_row(ftte_pkg::MAGIC_NATIVE, 25'd3, 1'b0);
        add_row(32'd1, 25'd3, 1'b0);
        add_checked(32'd4, 25'd3, ftte_pkg::ST_OVERRUN);
        add_row(ftte_pkg::MAGIC_NATIVE, 25'd7, 1'b0);
        add_row(32'd1, 25'd7, 1'b0);
        add_row(32'd16, 25'd7, 1'b0);
        add_row(32'hD800_1234, 25'd7, 1'b0);
        add_row(32'hABCD_0000, 25'd7, 1'b0);
        add_row(32'h0, 25'd7, 1'b0);
        add_row(32'h7FFFFFFF, 25'd7, 1'b1);
    endfunction

    // sender
    initial begin
        int n;
        int burst;
        int gap;
        int i;
        verdict_t v;
        stim_row_t r;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        word_value   = '0;
        packet_words = '0;
        last_word    = 1'b0;
        stim_done    = 1'b0;
        errors       = 0;
        mismatches   = 0;
        clear_state();
        build_directed();
        while (rows.size() < 640) build_packet($urandom_range(0, 3) == 0);
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        n = 0;
        burst = 0;
        while (n < rows.size()) begin
            if (burst == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
                burst = $urandom_range(1, 30);
            end
            r            = rows[n];
            in_valid     = 1'b1;
            word_value   = r.w;
            packet_words = r.pw;
            last_word    = r.last;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            if (predict_word(r.w, r.pw, r.last, v)) begin
                if (r.has_exp && v != r.exp) begin
                    errors++;
                    $display("table row %0d disagrees with prediction", n);
                end
                expected_q.push_back(v);
            end
            n++;
            burst--;
            @(negedge clk);
            if (burst == 0 || n == rows.size()) in_valid = 1'b0;
        end
        stim_done = 1'b1;
    end

    // receiver with its own stall pattern and one long hold-off
    initial begin
        int k;
        int c;
        out_ready = 1'b0;
        hold_off  = 1'b0;
        @(posedge rst_n);
        k = 0;
        forever begin
            @(negedge clk);
            k++;
            if (k == 300) begin
                hold_off  = 1'b1;
                out_ready = 1'b0;
                for (c = 0; c < 200; c++) @(negedge clk);
                hold_off = 1'b0;
            end
            if (k > 1500 && k < 1800) out_ready = 1'b1;
            else out_ready = ((k % 7) < 4) || ($urandom_range(0, 2) == 0);
        end
    end

    // result check
    always @(posedge clk) begin
        verdict_t e;
        if (rst_n && out_valid && out_ready) begin
            if (expected_q.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected result status=%0d", status);
            end
            else begin
                e = expected_q.pop_front();
                if (status != e.st || trigger_number != e.trig || tag_word != e.tag) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch exp %0d %h %h got %0d %h %h",
                                 e.st, e.trig, e.tag, status, trigger_number, tag_word);
                end
            end
        end
    end

    // watchdog and end of run
    initial begin
        int tail;
        idle_cycles = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles > 2000) begin
                $display("FAIL");
                $finish;
            end
            if (stim_done && expected_q.size() == 0) begin
                for (tail = 0; tail < 20; tail++) @(posedge clk);
                if (errors == 0 && expected_q.size() == 0)
                    $display("PASS");
                else
                    $display("FAIL");
                $finish;
            end
        end
    end
endmodule

// ===== frame_table_trigger_extractor.f =====
hdl/ftte_pkg.sv
hdl/ftte_front.sv
hdl/ftte_queue.sv
hdl/ftte_back.sv
hdl/frame_table_trigger_extractor.sv
tb/sv/testbench.sv
